FILE: sv/mch_pkg.sv
// Shared types and constants for the magnetometer compass heading block.
// Holds the input and output word types, the datapath command and status
// structs and the CORDIC arctangent table. Depends on nothing else.
package mch_pkg;

	// Field and register widths.
	localparam int MAG_W    = 16;
	localparam int ABS_W    = 17;
	localparam int THR_W    = 15;
	localparam int HEAD_W   = 15;
	localparam int SECT_W   = 4;
	localparam int ITER_W   = 5;
	localparam int XY_W     = 36;
	localparam int Z_W      = 33;
	localparam int ANG_W    = 34;
	localparam int TAB_W    = 31;

	// Angle accumulator holds degrees with this many fraction bits.
	localparam int ACC_FRAC  = 24;
	localparam int TABLE_LEN = 24;

	localparam logic [ANG_W-1:0] RIGHT_ANGLE = ANG_W'(90)  << ACC_FRAC;
	localparam logic [ANG_W-1:0] HALF_TURN   = ANG_W'(180) << ACC_FRAC;
	localparam logic [ANG_W-1:0] FULL_TURN   = ANG_W'(360) << ACC_FRAC;

	localparam logic [THR_W-1:0] CAL_THRESHOLD_RESET = 15'd50;

	// Sector divide by 90 through a reciprocal multiply, exact for inputs below 2^14.
	localparam int SECT_N_W   = 18;
	localparam int SECT_V_W   = 14;
	localparam int SECT_M_W   = 15;
	localparam int SECT_P_W   = 29;
	localparam int SECT_SHIFT = 21;
	localparam logic [SECT_M_W-1:0] SECT_RECIP = 15'd23302;

	// Opcodes of the input word.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic                    opcode;
		logic signed [MAG_W-1:0] mag_x;
		logic signed [MAG_W-1:0] mag_y;
	} in_word_t;

	typedef struct packed {
		logic [HEAD_W-1:0] heading;
		logic [SECT_W-1:0] sector;
		logic              calibrated;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic step;
		logic fold;
		logic round;
		logic sect;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic iter_last;
	} dp_status_t;

	// atan(2^-i) in degrees with ACC_FRAC fraction bits, rounded to nearest.
	function automatic logic [TAB_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
		logic [TAB_W-1:0] v;
		case (idx)
			5'd0:    v = 31'd754974720;
			5'd1:    v = 31'd445687602;
			5'd2:    v = 31'd235489089;
			5'd3:    v = 31'd119537938;
			5'd4:    v = 31'd60000934;
			5'd5:    v = 31'd30029717;
			5'd6:    v = 31'd15018523;
			5'd7:    v = 31'd7509720;
			5'd8:    v = 31'd3754917;
			5'd9:    v = 31'd1877466;
			5'd10:   v = 31'd938734;
			5'd11:   v = 31'd469367;
			5'd12:   v = 31'd234683;
			5'd13:   v = 31'd117342;
			5'd14:   v = 31'd58671;
			5'd15:   v = 31'd29335;
			5'd16:   v = 31'd14668;
			5'd17:   v = 31'd7334;
			5'd18:   v = 31'd3667;
			5'd19:   v = 31'd1833;
			5'd20:   v = 31'd917;
			5'd21:   v = 31'd458;
			5'd22:   v = 31'd229;
			5'd23:   v = 31'd115;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/mch_datapath.sv
// Datapath of the compass heading block: CORDIC vectoring registers, quadrant
// fold, rounding, sector divide, calibration flag and the output register.
// Depends on mch_pkg; driven by mch_controller through dp_cmd_t.
module mch_datapath
	import mch_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 6,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_status_t        status,
	input  in_word_t          in_word,
	input  logic              cfg_we,
	input  logic [THR_W-1:0]  cfg_wdata,
	output out_word_t         out_word
);

	localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int RSH   = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam logic [ANG_W-1:0]    ROUND_BIAS = ANG_W'(1) << (RSH - 1);
	localparam logic [ANG_W-1:0]    HEAD_WRAP  = ANG_W'(360) << ANGLE_FRAC_BITS;
	localparam logic [SECT_N_W-1:0] SECT_BIAS  = SECT_N_W'(45) << ANGLE_FRAC_BITS;
	localparam logic [ITER_W-1:0]   ITER_LAST  = ITER_W'(STEPS - 1);

	logic signed [XY_W-1:0]  x_q, y_q;
	logic signed [Z_W-1:0]   z_q;
	logic [ITER_W-1:0]       iter_q;
	logic                    x_neg_q, y_neg_q, ax_zero_q, ay_zero_q;
	logic [ANG_W-1:0]        ang_q;
	logic [HEAD_W-1:0]       last_heading_q;
	logic [SECT_W-1:0]       sector_q;
	logic                    cal_flag_q;
	logic [THR_W-1:0]        threshold_q;
	out_word_t               out_q;

	// Magnitudes of the incoming sample; the most negative code gives 32768.
	logic [ABS_W-1:0] ax, ay;
	logic             over_thr;

	always_comb begin
		ax = in_word.mag_x[MAG_W-1] ? (ABS_W'(0) - {in_word.mag_x[MAG_W-1], in_word.mag_x})
			: {1'b0, in_word.mag_x};
		ay = in_word.mag_y[MAG_W-1] ? (ABS_W'(0) - {in_word.mag_y[MAG_W-1], in_word.mag_y})
			: {1'b0, in_word.mag_y};
		over_thr = (ax > {2'b00, threshold_q}) || (ay > {2'b00, threshold_q});
	end

	// One CORDIC micro-rotation per cycle; shifts floor toward minus infinity.
	logic signed [XY_W-1:0] dx, dy, x_nx, y_nx;
	logic signed [Z_W-1:0]  tab_s, z_nx;

	always_comb begin
		dx    = y_q >>> iter_q;
		dy    = x_q >>> iter_q;
		tab_s = $signed({2'b00, atan_entry(iter_q)});
		if (!y_q[XY_W-1]) begin
			x_nx = x_q + dx;
			y_nx = y_q - dy;
			z_nx = z_q + tab_s;
		end else begin
			x_nx = x_q - dx;
			y_nx = y_q + dy;
			z_nx = z_q - tab_s;
		end
	end

	assign status.iter_last = (iter_q == ITER_LAST);

	// Clamp to the first quadrant, apply the axis cases and fold by the signs.
	logic [ANG_W-1:0] z_ext, a_sel, ang_nx;

	always_comb begin
		z_ext = {1'b0, z_q};
		if (ay_zero_q) begin
			a_sel = '0;
		end else if (ax_zero_q) begin
			a_sel = RIGHT_ANGLE;
		end else if (z_q[Z_W-1]) begin
			a_sel = '0;
		end else if (z_ext > RIGHT_ANGLE) begin
			a_sel = RIGHT_ANGLE;
		end else begin
			a_sel = z_ext;
		end
		case ({x_neg_q, y_neg_q})
			2'b00:   ang_nx = a_sel;
			2'b10:   ang_nx = HALF_TURN - a_sel;
			2'b11:   ang_nx = HALF_TURN + a_sel;
			default: ang_nx = (a_sel == '0) ? '0 : FULL_TURN - a_sel;
		endcase
	end

	// Round half up; angles within half a step below 360 degrees reach the wrap value.
	logic [ANG_W-1:0] h_full;

	always_comb begin
		h_full = (ang_q + ROUND_BIAS) >> RSH;
	end

	// Sector is floor((4h + 45 * 2^F) / (90 * 2^F)) mod 16.
	logic [SECT_N_W-1:0] sect_n;
	logic [SECT_V_W-1:0] sect_v;
	logic [SECT_P_W-1:0] sect_p;

	always_comb begin
		sect_n = {1'b0, last_heading_q, 2'b00} + SECT_BIAS;
		sect_v = SECT_V_W'(sect_n >> ANGLE_FRAC_BITS);
		sect_p = SECT_P_W'(sect_v) * SECT_P_W'(SECT_RECIP);
	end

	// Working registers of the CORDIC and fold, the sector and the output register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q       <= XY_W'({ax, 16'h0000});
			y_q       <= XY_W'({ay, 16'h0000});
			z_q       <= '0;
			x_neg_q   <= in_word.mag_x[MAG_W-1];
			y_neg_q   <= in_word.mag_y[MAG_W-1];
			ax_zero_q <= (ax == '0);
			ay_zero_q <= (ay == '0);
		end else if (cmd.step) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
		if (cmd.fold) begin
			ang_q <= ang_nx;
		end
		if (cmd.sect) begin
			sector_q <= sect_p[SECT_SHIFT +: SECT_W];
		end
		if (cmd.emit) begin
			out_q.heading    <= last_heading_q;
			out_q.sector     <= sector_q;
			out_q.calibrated <= cal_flag_q;
		end
	end

	// Iteration counter, architectural state and the threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q         <= '0;
			last_heading_q <= '0;
			cal_flag_q     <= 1'b0;
			threshold_q    <= CAL_THRESHOLD_RESET;
		end else begin
			if (cmd.load) begin
				iter_q <= '0;
			end else if (cmd.step) begin
				iter_q <= iter_q + ITER_W'(1);
			end
			if (cmd.load) begin
				if (in_word.opcode == OP_CLEAR) begin
					cal_flag_q <= 1'b0;
				end else if (over_thr) begin
					cal_flag_q <= 1'b1;
				end
			end
			if (cmd.round) begin
				last_heading_q <= (h_full == HEAD_WRAP) ? '0 : h_full[HEAD_W-1:0];
			end
			if (cfg_we) begin
				threshold_q <= cfg_wdata;
			end
		end
	end

	assign out_word = out_q;

endmodule

FILE: sv/mch_controller.sv
// Sequencing state machine of the compass heading block.
// Issues dp_cmd_t commands to mch_datapath and owns both handshakes.
// Depends on mch_pkg.
module mch_controller
	import mch_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_opcode,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ITER  = 3'd1;
	localparam logic [2:0] ST_FOLD  = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_SECT  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q, state_nx;
	logic       out_valid_q;
	logic       accept, out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Next state and datapath commands.
	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_nx = (in_opcode == OP_CLEAR) ? ST_SECT : ST_ITER;
				end
			end
			ST_ITER: begin
				cmd.step = 1'b1;
				if (status.iter_last) begin
					state_nx = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_nx = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_nx  = ST_SECT;
			end
			ST_SECT: begin
				cmd.sect = 1'b1;
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/magnetometer_compass_heading.sv
// Top level of the magnetometer compass heading block.
// Instantiates mch_controller and mch_datapath; depends on mch_pkg.
//
// Usage:
// The input channel (in_valid, in_stall, in_word) takes one word per item:
// a sample (mag_x, mag_y) or a clear of the calibrated flag. The output
// channel (out_valid, out_stall, out_word) returns exactly one word per item
// with the heading in 1/2^ANGLE_FRAC_BITS degree, the 16-point sector and
// the calibrated flag. A word moves at a clock edge where valid is high and
// stall is low.
// A sample passes from acceptance through the CORDIC iterations, run by the
// single shared CORDIC micro-rotation stage once per cycle, then the fold,
// round, sector and done states to output valid; a clear word goes straight
// to the sector and done states. The block takes no new word while an item
// is in flight. The next word is accepted on the cycle after a result moves
// into the output register, even while that result still waits.
// If the receiver stalls, the result holds in the output register and the
// finished item after it waits in the datapath until the register frees.
// cfg_we writes cfg_wdata into the calibration threshold; write it only
// while the block is idle. Reset clears the flag, the last heading and
// the handshakes, and sets the threshold to 50.
module magnetometer_compass_heading
	import mch_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 6,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata
);

	localparam logic [ANG_W-1:0] HEAD_LIMIT = ANG_W'(360) << ANGLE_FRAC_BITS;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer.
	mch_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (in_word.opcode),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	mch_datapath #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.CORDIC_STEPS    (CORDIC_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_word  (out_word)
	);

`ifndef SYNTHESIS
	// An accepted word makes the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	// A delivered heading stays below a full turn when it fits the field.
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (ANGLE_FRAC_BITS <= 6) |-> ({19'b0, out_word.heading} < HEAD_LIMIT))
		else $error("heading out of range");

	// A word is only loaded into the output register from the done state, and the load raises out_valid.
	a_emit_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("output valid missing after emit");
`endif

endmodule
